// ----- src/mqlb_pkg.sv -----
package mqlb_pkg;

    localparam int DATA_W   = 32;
    localparam int CMD_W    = 1;
    localparam int QNUM_W   = 2;
    localparam int STATUS_W = 2;

    localparam logic [CMD_W-1:0] CMD_ENQ = 1'b0;
    localparam logic [CMD_W-1:0] CMD_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_LINK,
        S_POP
    } t_state;

endpackage

// ----- src/mqlb_if.sv -----
interface mqlb_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [mqlb_pkg::CMD_W-1:0]           command;
    logic [mqlb_pkg::QNUM_W-1:0]          queue_number;
    logic signed [mqlb_pkg::DATA_W-1:0]   push_value;

    modport source (output valid, command, queue_number, push_value, input ready);
    modport sink   (input valid, command, queue_number, push_value, output ready);
endinterface

interface mqlb_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic [mqlb_pkg::STATUS_W-1:0]        status;
    logic signed [mqlb_pkg::DATA_W-1:0]   popped_value;

    modport source (output valid, status, popped_value, input ready);
    modport sink   (input valid, status, popped_value, output ready);
endinterface

// ----- src/mqlb_ram.sv -----
module mqlb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                    i_wdata,
    input  logic                                i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                    o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/multi_queue_linked_buffer.sv -----
// NUM_QUEUES FIFO queues share one store of NUM_SLOTS data slots; free slots
// form a linked list. Each request enqueues push_value to a queue or dequeues
// from it, and yields exactly one response: done, store full (enqueue with no
// free slot or queue number out of range) or queue empty (dequeue). One request
// is handled at a time. A failed request and an enqueue to an empty queue finish
// in the lookup step; an enqueue to a non-empty queue and a successful dequeue
// also need the link or pop step, because each writes the link memory (one write
// port) at two slots, or reads it and then writes it back. A response register
// lets the next request in while the previous response waits; a request stalls
// at any step while that register is full and not taken. No clearing pass
// follows reset: never-used slots are tracked by a fill counter.
module multi_queue_linked_buffer #(
    parameter int NUM_SLOTS  = 16,
    parameter int NUM_QUEUES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mqlb_req_if.sink    i_req,
    mqlb_rsp_if.source  o_rsp
);

    localparam int SW = $clog2(NUM_SLOTS);
    localparam int LW = $clog2(NUM_SLOTS + 1);
    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int DW = mqlb_pkg::DATA_W;
    localparam logic [LW-1:0] LINK_NULL = LW'(NUM_SLOTS);

    mqlb_pkg::t_state r_state, n_state;

    logic [mqlb_pkg::CMD_W-1:0]     r_cmd;
    logic [mqlb_pkg::QNUM_W-1:0]    r_q;
    logic [DW-1:0]                  r_val;
    logic [LW-1:0]                  r_head;
    logic [LW-1:0]                  r_tail;
    logic [LW-1:0]                  r_slot;
    logic [LW-1:0]                  r_free;
    logic [LW-1:0]                  r_fill;
    logic [NUM_QUEUES-1:0]          r_qvalid;
    logic                           r_out_valid;
    logic [mqlb_pkg::STATUS_W-1:0]  r_status;
    logic signed [DW-1:0]           r_popped;

    logic                   q_we, q_re;
    logic [QW-1:0]          q_waddr, q_raddr;
    logic [2*LW-1:0]        q_wdata, q_rdata;
    logic                   l_we, l_re;
    logic [SW-1:0]          l_waddr, l_raddr;
    logic [LW-1:0]          l_wdata, l_rdata;
    logic                   d_we, d_re;
    logic [SW-1:0]          d_waddr, d_raddr;
    logic [DW-1:0]          d_wdata, d_rdata;

    logic                   accept, can_fin, fin;
    logic [QW+1:0]          q_in_ext, q_cur_ext;
    logic [QW-1:0]          qa;
    logic                   q_ok, hv, free_null, fresh, enq_ok, deq_ok;
    logic [LW-1:0]          head_rd, tail_rd, next_free;
    logic [mqlb_pkg::STATUS_W-1:0] n_status;
    logic [DW-1:0]          n_popped;

    mqlb_ram #(.WIDTH(2 * LW), .DEPTH(NUM_QUEUES)) u_qram (
        .i_clk  (i_clk),
        .i_we   (q_we),
        .i_waddr(q_waddr),
        .i_wdata(q_wdata),
        .i_re   (q_re),
        .i_raddr(q_raddr),
        .o_rdata(q_rdata)
    );

    mqlb_ram #(.WIDTH(LW), .DEPTH(NUM_SLOTS)) u_link (
        .i_clk  (i_clk),
        .i_we   (l_we),
        .i_waddr(l_waddr),
        .i_wdata(l_wdata),
        .i_re   (l_re),
        .i_raddr(l_raddr),
        .o_rdata(l_rdata)
    );

    mqlb_ram #(.WIDTH(DW), .DEPTH(NUM_SLOTS)) u_data (
        .i_clk  (i_clk),
        .i_we   (d_we),
        .i_waddr(d_waddr),
        .i_wdata(d_wdata),
        .i_re   (d_re),
        .i_raddr(d_raddr),
        .o_rdata(d_rdata)
    );

    assign i_req.ready        = (r_state == mqlb_pkg::S_IDLE);
    assign accept             = i_req.valid && i_req.ready;
    assign can_fin            = !r_out_valid || o_rsp.ready;
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_status;
    assign o_rsp.popped_value = r_popped;

    assign q_in_ext  = (QW + 2)'(i_req.queue_number);
    assign q_cur_ext = (QW + 2)'(r_q);
    assign qa        = q_cur_ext[QW-1:0];
    assign q_ok      = (int'(r_q) < NUM_QUEUES);
    assign head_rd   = (q_ok && r_qvalid[qa]) ? q_rdata[2*LW-1:LW] : LINK_NULL;
    assign tail_rd   = (q_ok && r_qvalid[qa]) ? q_rdata[LW-1:0] : LINK_NULL;
    assign hv        = (head_rd != LINK_NULL);
    assign free_null = (r_free == LINK_NULL);
    assign fresh     = (r_free == r_fill);
    assign next_free = fresh ? LW'(r_fill + 1'b1) : l_rdata;
    assign enq_ok    = (r_cmd == mqlb_pkg::CMD_ENQ) && q_ok && !free_null;
    assign deq_ok    = (r_cmd == mqlb_pkg::CMD_DEQ) && hv;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mqlb_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = mqlb_pkg::S_LOOKUP;
                end
            end
            mqlb_pkg::S_LOOKUP: begin
                if (can_fin) begin
                    priority if (enq_ok && hv) begin
                        n_state = mqlb_pkg::S_LINK;
                    end else if (deq_ok) begin
                        n_state = mqlb_pkg::S_POP;
                    end else begin
                        n_state = mqlb_pkg::S_IDLE;
                    end
                end
            end
            mqlb_pkg::S_LINK, mqlb_pkg::S_POP: begin
                if (can_fin) begin
                    n_state = mqlb_pkg::S_IDLE;
                end
            end
            default: n_state = mqlb_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        q_we     = 1'b0;
        q_re     = 1'b0;
        q_waddr  = qa;
        q_raddr  = q_in_ext[QW-1:0];
        q_wdata  = '0;
        l_we     = 1'b0;
        l_re     = 1'b0;
        l_waddr  = '0;
        l_raddr  = '0;
        l_wdata  = '0;
        d_we     = 1'b0;
        d_re     = 1'b0;
        d_waddr  = r_free[SW-1:0];
        d_raddr  = head_rd[SW-1:0];
        d_wdata  = r_val;
        fin      = 1'b0;
        n_status = mqlb_pkg::ST_DONE;
        n_popped = '0;
        unique case (r_state)
            mqlb_pkg::S_IDLE: begin
                if (accept) begin
                    q_re    = 1'b1;
                    l_re    = 1'b1;
                    l_raddr = r_free[SW-1:0];
                end
            end
            mqlb_pkg::S_LOOKUP: begin
                if (can_fin) begin
                    if (r_cmd == mqlb_pkg::CMD_ENQ) begin
                        if (!enq_ok) begin
                            fin      = 1'b1;
                            n_status = mqlb_pkg::ST_FULL;
                        end else begin
                            l_we    = 1'b1;
                            l_waddr = r_free[SW-1:0];
                            l_wdata = LINK_NULL;
                            d_we    = 1'b1;
                            q_we    = 1'b1;
                            q_wdata = {(hv ? head_rd : r_free), r_free};
                            fin     = !hv;
                        end
                    end else begin
                        if (!deq_ok) begin
                            fin      = 1'b1;
                            n_status = mqlb_pkg::ST_EMPTY;
                        end else begin
                            l_re    = 1'b1;
                            l_raddr = head_rd[SW-1:0];
                            d_re    = 1'b1;
                        end
                    end
                end
            end
            mqlb_pkg::S_LINK: begin
                if (can_fin) begin
                    l_we    = 1'b1;
                    l_waddr = r_tail[SW-1:0];
                    l_wdata = r_slot;
                    fin     = 1'b1;
                end
            end
            mqlb_pkg::S_POP: begin
                if (can_fin) begin
                    l_we     = 1'b1;
                    l_waddr  = r_head[SW-1:0];
                    l_wdata  = r_free;
                    q_we     = 1'b1;
                    q_wdata  = {l_rdata, r_tail};
                    fin      = 1'b1;
                    n_popped = d_rdata;
                end
            end
            default: begin
                fin = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mqlb_pkg::S_IDLE;
            r_free      <= '0;
            r_fill      <= '0;
            r_qvalid    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fin) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (q_we) begin
                r_qvalid[qa] <= 1'b1;
            end
            if (r_state == mqlb_pkg::S_LOOKUP && can_fin && enq_ok) begin
                r_free <= next_free;
                if (fresh) begin
                    r_fill <= LW'(r_fill + 1'b1);
                end
            end
            if (r_state == mqlb_pkg::S_POP && can_fin) begin
                r_free <= r_head;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_req.command;
            r_q   <= i_req.queue_number;
            r_val <= i_req.push_value;
        end
        if (r_state == mqlb_pkg::S_LOOKUP && can_fin) begin
            r_head <= head_rd;
            r_tail <= tail_rd;
            r_slot <= r_free;
        end
        if (fin) begin
            r_status <= n_status;
            r_popped <= n_popped;
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_fill) <= NUM_SLOTS)
        else $error("fill counter beyond slot count");

    a_free_behind_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free == LINK_NULL) || (r_free <= r_fill))
        else $error("free head points past never-used slots");

    a_link_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(l_we && l_re))
        else $error("link memory read and written in one cycle");

    a_link_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mqlb_pkg::S_LINK || r_state == mqlb_pkg::S_POP) |->
        ($past(r_state) == mqlb_pkg::S_LOOKUP || $past(r_state) == r_state))
        else $error("second memory step entered without lookup");

endmodule

// ----- test/multi_queue_linked_buffer_tb.sv -----
module multi_queue_linked_buffer_tb;

    localparam int SLOTS       = 16;
    localparam int QUEUES      = 4;
    localparam int HOLD_CYCLES = 200;
    localparam int PRINT_CAP   = 100;
    localparam logic [4:0] NIL = 5'(SLOTS);

    typedef struct packed {
        logic [mqlb_pkg::STATUS_W-1:0]      status;
        logic signed [mqlb_pkg::DATA_W-1:0] popped_value;
    } t_rsp;

    typedef struct {
        logic [mqlb_pkg::CMD_W-1:0]         cmd;
        logic [mqlb_pkg::QNUM_W-1:0]        qn;
        logic signed [mqlb_pkg::DATA_W-1:0] value;
        bit                                 typed;
        t_rsp                               exp;
    } t_request;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mqlb_req_if req_if();
    mqlb_rsp_if rsp_if();

    multi_queue_linked_buffer #(
        .NUM_SLOTS  (SLOTS),
        .NUM_QUEUES (QUEUES)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #5 i_clk = ~i_clk;

    logic signed [mqlb_pkg::DATA_W-1:0] slot_word [SLOTS];
    logic [4:0]                         slot_next [SLOTS];
    logic [4:0]                         q_head [QUEUES];
    logic [4:0]                         q_tail [QUEUES];
    logic [4:0]                         free_first;

    t_rsp     expected_rsp [$];
    t_request directed_rows [$];

    bit   drv_typed;
    t_rsp drv_exp;

    int  tx_idle_pct;
    int  rx_idle_pct;
    bit  hold_off_req;
    int  items_sent;
    int  mismatch_count;
    int  rsp_count;
    int  enq_count;
    int  deq_count;
    int  full_count;
    int  empty_count;

    function automatic t_rsp predict_response(
        input logic [mqlb_pkg::CMD_W-1:0]         cmd,
        input logic [mqlb_pkg::QNUM_W-1:0]        qn,
        input logic signed [mqlb_pkg::DATA_W-1:0] value);
        t_rsp       r;
        logic [4:0] s;
        r.status       = mqlb_pkg::ST_DONE;
        r.popped_value = '0;
        if (cmd == mqlb_pkg::CMD_ENQ) begin
            if (free_first == NIL) begin
                r.status = mqlb_pkg::ST_FULL;
            end else begin
                s          = free_first;
                free_first = slot_next[s];
                if (q_head[qn] == NIL) begin
                    q_head[qn] = s;
                end else begin
                    slot_next[q_tail[qn]] = s;
                end
                slot_next[s] = NIL;
                q_tail[qn]   = s;
                slot_word[s] = value;
            end
        end else begin
            if (q_head[qn] == NIL) begin
                r.status = mqlb_pkg::ST_EMPTY;
            end else begin
                s              = q_head[qn];
                q_head[qn]     = slot_next[s];
                slot_next[s]   = free_first;
                free_first     = s;
                r.popped_value = slot_word[s];
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_CAP) begin
            $display("[%0t] mismatch on response %0d: %s", $realtime, rsp_count, what);
        end
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_rsp pred;
        t_rsp exp;
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                pred = predict_response(req_if.command, req_if.queue_number,
                                        req_if.push_value);
                expected_rsp.push_back(drv_typed ? drv_exp : pred);
                if (req_if.command == mqlb_pkg::CMD_ENQ) enq_count++;
                else deq_count++;
                if (pred.status == mqlb_pkg::ST_FULL) full_count++;
                if (pred.status == mqlb_pkg::ST_EMPTY) empty_count++;
            end
            if (rsp_if.valid && rsp_if.ready) begin
                if (expected_rsp.size() == 0) begin
                    report_mismatch("response with no request outstanding");
                end else begin
                    exp = expected_rsp.pop_front();
                    if (rsp_if.status !== exp.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  rsp_if.status, exp.status));
                    end
                    if (rsp_if.popped_value !== exp.popped_value) begin
                        report_mismatch($sformatf("popped_value %h, expected %h",
                                                  rsp_if.popped_value, exp.popped_value));
                    end
                end
                rsp_count++;
            end
        end
    end

    initial begin
        int hold;
        rsp_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                rsp_if.ready <= 1'b0;
            end else if (hold_off_req) begin
                hold_off_req = 1'b0;
                rsp_if.ready <= 1'b0;
                for (hold = 0; hold < HOLD_CYCLES; hold++) @(posedge i_clk);
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    function automatic void add_row(input logic [mqlb_pkg::CMD_W-1:0] cmd,
                                    input logic [mqlb_pkg::QNUM_W-1:0] qn,
                                    input logic signed [mqlb_pkg::DATA_W-1:0] value,
                                    input bit typed,
                                    input logic [mqlb_pkg::STATUS_W-1:0] status,
                                    input logic signed [mqlb_pkg::DATA_W-1:0] popped);
        t_request row;
        row.cmd                = cmd;
        row.qn                 = qn;
        row.value              = value;
        row.typed              = typed;
        row.exp.status         = status;
        row.exp.popped_value   = popped;
        directed_rows.push_back(row);
    endfunction

    task automatic send_request(input t_request row);
        if ($urandom_range(99) < tx_idle_pct) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.command      <= row.cmd;
        req_if.queue_number <= row.qn;
        req_if.push_value   <= row.value;
        drv_typed           <= row.typed;
        drv_exp             <= row.exp;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_random_burst(input int count);
        t_request row;
        int       enq_pct;
        int       focus_q;
        enq_pct = 30 + 20 * $urandom_range(3);
        focus_q = $urandom_range(QUEUES - 1);
        row.typed = 1'b0;
        row.exp   = '0;
        repeat (count) begin
            row.cmd = ($urandom_range(99) < enq_pct) ? mqlb_pkg::CMD_ENQ : mqlb_pkg::CMD_DEQ;
            row.qn  = $urandom_range(1) ? mqlb_pkg::QNUM_W'(focus_q)
                                        : mqlb_pkg::QNUM_W'($urandom_range(QUEUES - 1));
            case ($urandom_range(9))
                0:       row.value = 32'sh7FFF_FFFF;
                1:       row.value = 32'sh8000_0000;
                2:       row.value = (row.cmd == mqlb_pkg::CMD_ENQ) ? 32'sh0 : 32'shFFFF_FFFF;
                default: row.value = $urandom;
            endcase
            send_request(row);
        end
    endtask

    task automatic drain_responses();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_rsp.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int i;
        i_rst_n             = 1'b0;
        req_if.valid        = 1'b0;
        req_if.command      = mqlb_pkg::CMD_ENQ;
        req_if.queue_number = '0;
        req_if.push_value   = '0;
        drv_typed           = 1'b0;
        drv_exp             = '0;
        hold_off_req        = 1'b0;
        tx_idle_pct         = 33;
        rx_idle_pct         = 64;
        items_sent          = 0;
        mismatch_count      = 0;
        rsp_count           = 0;
        enq_count           = 0;
        deq_count           = 0;
        full_count          = 0;
        empty_count         = 0;
        for (i = 0; i < SLOTS; i++) begin
            slot_word[i] = '0;
            slot_next[i] = 5'(i + 1);
        end
        for (i = 0; i < QUEUES; i++) begin
            q_head[i] = NIL;
            q_tail[i] = NIL;
        end
        free_first = '0;

        add_row(mqlb_pkg::CMD_DEQ, 2'd0, 32'sh0, 1'b1, mqlb_pkg::ST_EMPTY, 32'sh0);
        add_row(mqlb_pkg::CMD_ENQ, 2'd0, 32'sh7FFF_FFFF, 1'b1, mqlb_pkg::ST_DONE, 32'sh0);
        add_row(mqlb_pkg::CMD_ENQ, 2'd1, 32'sh8000_0000, 1'b1, mqlb_pkg::ST_DONE, 32'sh0);
        add_row(mqlb_pkg::CMD_ENQ, 2'd2, 32'sh0, 1'b1, mqlb_pkg::ST_DONE, 32'sh0);
        add_row(mqlb_pkg::CMD_ENQ, 2'd3, 32'shFFFF_FFFF, 1'b1, mqlb_pkg::ST_DONE, 32'sh0);
        add_row(mqlb_pkg::CMD_DEQ, 2'd0, 32'shFFFF_FFFF, 1'b1, mqlb_pkg::ST_DONE,
                32'sh7FFF_FFFF);
        add_row(mqlb_pkg::CMD_DEQ, 2'd1, 32'sh0, 1'b1, mqlb_pkg::ST_DONE, 32'sh8000_0000);
        for (i = 0; i < SLOTS - 2; i++) begin
            add_row(mqlb_pkg::CMD_ENQ, mqlb_pkg::QNUM_W'(i % 2),
                    (i % 2) ? 32'sh5555_5555 : 32'shAAAA_AAAA,
                    1'b1, mqlb_pkg::ST_DONE, 32'sh0);
        end
        add_row(mqlb_pkg::CMD_ENQ, 2'd3, 32'sh1234_5678, 1'b1, mqlb_pkg::ST_FULL, 32'sh0);
        add_row(mqlb_pkg::CMD_DEQ, 2'd3, 32'sh0, 1'b1, mqlb_pkg::ST_DONE, 32'shFFFF_FFFF);
        add_row(mqlb_pkg::CMD_DEQ, 2'd2, 32'sh0, 1'b1, mqlb_pkg::ST_DONE, 32'sh0);
        add_row(mqlb_pkg::CMD_DEQ, 2'd0, 32'sh0, 1'b0, mqlb_pkg::ST_DONE, 32'sh0);
        add_row(mqlb_pkg::CMD_ENQ, 2'd3, 32'sh0F0F_0F0F, 1'b0, mqlb_pkg::ST_DONE, 32'sh0);
        add_row(mqlb_pkg::CMD_DEQ, 2'd3, 32'sh0, 1'b0, mqlb_pkg::ST_DONE, 32'sh0);
        add_row(mqlb_pkg::CMD_DEQ, 2'd3, 32'sh0, 1'b1, mqlb_pkg::ST_EMPTY, 32'sh0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) send_request(directed_rows[k]);
        while (items_sent < 340) send_random_burst($urandom_range(20, 40));
        drain_responses();

        tx_idle_pct = 64;
        rx_idle_pct = 33;
        while (items_sent < 670) send_random_burst($urandom_range(20, 40));
        drain_responses();

        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        hold_off_req = 1'b1;
        send_random_burst(40);
        while (items_sent < 1000) send_random_burst($urandom_range(20, 40));
        drain_responses();
        repeat (20) @(posedge i_clk);

        $display("Ran %0d requests: %0d enqueues, %0d dequeues, %0d responses checked.",
                 items_sent, enq_count, deq_count, rsp_count);
        $display("Store-full answers: %0d, queue-empty answers: %0d, mismatches: %0d.",
                 full_count, empty_count, mismatch_count);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Timed out with %0d responses outstanding.", expected_rsp.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- sim.f -----
src/mqlb_pkg.sv
src/mqlb_if.sv
src/mqlb_ram.sv
src/multi_queue_linked_buffer.sv
test/multi_queue_linked_buffer_tb.sv
